// ----- rtl/nnis_pkg.sv -----
package nnis_pkg;

    // configuration register widths
    localparam int SRC_WIDTH_W  = 10;
    localparam int SRC_HEIGHT_W = 9;
    localparam int TGT_SIZE_W   = 11;
    localparam int STRIDE_W     = 14;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 14;

    // payload widths
    localparam int COLOUR_W     = 8;
    localparam int RGB_W        = 3 * COLOUR_W;
    localparam int COORD_W      = 11;
    localparam int OFFSET_W     = 24;
    localparam int IN_TDATA_W   = 48;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 56;

    // product widths feeding the dividers and the store address
    localparam int NUM_X_W      = COORD_W + SRC_WIDTH_W;
    localparam int NUM_Y_W      = COORD_W + SRC_HEIGHT_W;
    localparam int PIX_INDEX_W  = SRC_WIDTH_W + SRC_HEIGHT_W;

    localparam int DEF_MAX_SRC_WIDTH  = 640;
    localparam int DEF_MAX_SRC_HEIGHT = 480;

    localparam logic [SRC_WIDTH_W-1:0]  RST_SRC_WIDTH  = 10'd640;
    localparam logic [SRC_HEIGHT_W-1:0] RST_SRC_HEIGHT = 9'd480;
    localparam logic [TGT_SIZE_W-1:0]   RST_TGT_WIDTH  = 11'd640;
    localparam logic [TGT_SIZE_W-1:0]   RST_TGT_HEIGHT = 11'd480;
    localparam logic [STRIDE_W-1:0]     RST_STRIDE     = 14'd2560;

    localparam logic [COLOUR_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_TGT_WIDTH  = 3'd2,
        CFG_TGT_HEIGHT = 3'd3,
        CFG_STRIDE     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic load;        // write the input beat into the store
        logic capture;     // latch the fetch coordinate
        logic div_start;   // launch both coordinate divisions
        logic map_en;      // clamp quotients, form offset
        logic prod_en;     // row times width
        logic read_en;     // issue store read
        logic out_load;    // fill the output register
    } nnis_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } nnis_status_t;

endpackage

// ----- rtl/nnis_ram.sv -----
module nnis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 307200,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/nnis_div.sv -----
module nnis_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DEN_W:0]   trial;
    logic             fits;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

// ----- rtl/nnis_ctrl.sv -----
module nnis_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 command,
    input  nnis_pkg::nnis_status_t status,
    output logic                 s_tready,
    output nnis_pkg::nnis_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_MAP,
        ST_PROD,
        ST_READ,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   beat;

    assign s_tready = (state_reg == ST_IDLE);
    assign beat     = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (beat && command == nnis_pkg::CMD_FETCH)
                begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:  state_next = ST_PROD;
            ST_PROD: state_next = ST_READ;
            ST_READ: state_next = ST_OUT;
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.load      = beat && command == nnis_pkg::CMD_LOAD;
        cmd.capture   = beat && command == nnis_pkg::CMD_FETCH;
        cmd.div_start = state_reg == ST_START;
        cmd.map_en    = state_reg == ST_MAP;
        cmd.prod_en   = state_reg == ST_PROD;
        cmd.read_en   = state_reg == ST_READ;
        cmd.out_load  = state_reg == ST_OUT && status.out_free;
    end

endmodule

// ----- rtl/nnis_datapath.sv -----
module nnis_datapath #(
    parameter int MAX_SRC_WIDTH  = nnis_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = nnis_pkg::DEF_MAX_SRC_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [nnis_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [nnis_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [nnis_pkg::IN_TUSER_W-1:0]    s_tuser,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [nnis_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  nnis_pkg::nnis_cmd_t                cmd,
    output nnis_pkg::nnis_status_t             status
);

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(DEPTH + 1);

    localparam int SWW = nnis_pkg::SRC_WIDTH_W;
    localparam int SHW = nnis_pkg::SRC_HEIGHT_W;
    localparam int TSW = nnis_pkg::TGT_SIZE_W;
    localparam int CW  = nnis_pkg::COORD_W;
    localparam int OW  = nnis_pkg::OFFSET_W;
    localparam int NXW = nnis_pkg::NUM_X_W;
    localparam int NYW = nnis_pkg::NUM_Y_W;
    localparam int PIW = nnis_pkg::PIX_INDEX_W;
    localparam int CLW = nnis_pkg::COLOUR_W;

    // configuration
    logic [SWW-1:0]                  src_w_reg;
    logic [SHW-1:0]                  src_h_reg;
    logic [TSW-1:0]                  tgt_w_reg;
    logic [TSW-1:0]                  tgt_h_reg;
    logic [nnis_pkg::STRIDE_W-1:0]   stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= nnis_pkg::RST_SRC_WIDTH;
            src_h_reg  <= nnis_pkg::RST_SRC_HEIGHT;
            tgt_w_reg  <= nnis_pkg::RST_TGT_WIDTH;
            tgt_h_reg  <= nnis_pkg::RST_TGT_HEIGHT;
            stride_reg <= nnis_pkg::RST_STRIDE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nnis_pkg::CFG_SRC_WIDTH:  src_w_reg  <= cfg_data[SWW-1:0];
                nnis_pkg::CFG_SRC_HEIGHT: src_h_reg  <= cfg_data[SHW-1:0];
                nnis_pkg::CFG_TGT_WIDTH:  tgt_w_reg  <= cfg_data[TSW-1:0];
                nnis_pkg::CFG_TGT_HEIGHT: tgt_h_reg  <= cfg_data[TSW-1:0];
                nnis_pkg::CFG_STRIDE:     stride_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, source capped at the store geometry
    logic [SWW-1:0] sw;
    logic [SHW-1:0] sh;
    logic [TSW-1:0] tw;
    logic [TSW-1:0] th;

    always_comb
    begin
        if (src_w_reg == '0)
            sw = SWW'(1);
        else if (32'(src_w_reg) > 32'(MAX_SRC_WIDTH))
            sw = SWW'(MAX_SRC_WIDTH);
        else
            sw = src_w_reg;

        if (src_h_reg == '0)
            sh = SHW'(1);
        else if (32'(src_h_reg) > 32'(MAX_SRC_HEIGHT))
            sh = SHW'(MAX_SRC_HEIGHT);
        else
            sh = src_h_reg;

        tw = (tgt_w_reg == '0) ? TSW'(1) : tgt_w_reg;
        th = (tgt_h_reg == '0) ? TSW'(1) : tgt_h_reg;
    end

    // load path
    logic [IW-1:0]             wr_index_reg;
    logic [IW-1:0]             wr_base;
    logic                      wr_room;
    logic                      store_we;
    logic [nnis_pkg::RGB_W-1:0] store_wdata;

    assign wr_base     = s_tuser[1] ? '0 : wr_index_reg;
    assign wr_room     = 32'(wr_base) < 32'(DEPTH);
    assign store_we    = cmd.load && wr_room;
    assign store_wdata = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_index_reg <= '0;
        end
        else if (cmd.load)
        begin
            // store full: index stays saturated at the depth
            wr_index_reg <= wr_room ? wr_base + 1'b1 : wr_base;
        end
    end

    // fetch path
    logic [CW-1:0]    tx_reg;
    logic [CW-1:0]    ty_reg;
    logic [OW:0]      off_prod_reg;
    logic [OW-1:0]    offset_reg;
    logic [SWW-1:0]   sx_reg;
    logic [SHW-1:0]   sy_reg;
    logic [PIW-1:0]   row_base_reg;
    logic [NXW-1:0]   qx;
    logic [NYW-1:0]   qy;
    logic             busy_x;
    logic             busy_y;
    logic [PIW-1:0]   pix_index;
    logic [nnis_pkg::RGB_W-1:0] rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tx_reg <= s_tdata[34:24];
            ty_reg <= s_tdata[45:35];
        end
        if (cmd.div_start)
        begin
            off_prod_reg <= (OW+1)'(ty_reg * stride_reg);
        end
        if (cmd.map_en)
        begin
            offset_reg <= OW'(off_prod_reg) + OW'({tx_reg, 2'b00});
            sx_reg     <= (qx >= NXW'(sw)) ? sw - 1'b1 : qx[SWW-1:0];
            sy_reg     <= (qy >= NYW'(sh)) ? sh - 1'b1 : qy[SHW-1:0];
        end
        if (cmd.prod_en)
        begin
            row_base_reg <= PIW'(sy_reg * sw);
        end
    end

    assign pix_index = row_base_reg + PIW'(sx_reg);

    nnis_div #(
        .NUM_W (NXW),
        .DEN_W (TSW)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (NXW'(tx_reg * sw)),
        .denom (tw),
        .busy  (busy_x),
        .quot  (qx)
    );

    nnis_div #(
        .NUM_W (NYW),
        .DEN_W (TSW)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (NYW'(ty_reg * sh)),
        .denom (th),
        .busy  (busy_y),
        .quot  (qy)
    );

    nnis_ram #(
        .WIDTH (nnis_pkg::RGB_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (AW'(wr_base)),
        .wdata (store_wdata),
        .re    (cmd.read_en),
        .raddr (AW'(pix_index)),
        .rdata (rdata)
    );

    // output register
    logic                           out_valid_reg;
    logic [nnis_pkg::OUT_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {nnis_pkg::ALPHA_OPAQUE, rdata[3*CLW-1:2*CLW],
                             rdata[2*CLW-1:CLW], rdata[CLW-1:0], offset_reg};
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign status.div_done = !busy_x && !busy_y;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

// ----- rtl/nearest_neighbor_image_scaler_top.sv -----
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  one load or fetch command
// m_*      out  m_tvalid/m_tready  one pixel write for each fetch
// cfg_*    in   cfg_we             register write, no wait
//
// A load is written to the store on its beat; loads stream at one beat a clock
// while no fetch is in progress. A fetch passes through a start step, the two
// shift-subtract dividers (one quotient bit a clock), then map, multiply, store
// read and output load, and no further beat is taken until it is done. The
// result sits in an output register; a stalled master side holds the next fetch
// in its final step. Reset clears control and configuration, not the pixel
// store.
module nearest_neighbor_image_scaler_top #(
    parameter int MAX_SRC_WIDTH  = nnis_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = nnis_pkg::DEF_MAX_SRC_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [nnis_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // red_in, green_in, blue_in, target_x, target_y, 2 zero bits
    input  logic [nnis_pkg::IN_TDATA_W-1:0]  s_tdata,
    // command, first_pixel
    input  logic [nnis_pkg::IN_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fb_offset, blue_out, green_out, red_out, alpha_out
    output logic [nnis_pkg::OUT_TDATA_W-1:0] m_tdata
);

    nnis_pkg::nnis_cmd_t    cmd;
    nnis_pkg::nnis_status_t status;

    nnis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .command  (s_tuser[0]),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    nnis_datapath #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    import nnis_pkg::*;

    localparam int STORE_DEPTH   = DEF_MAX_SRC_WIDTH * DEF_MAX_SRC_HEIGHT;
    localparam int RANDOM_BEATS  = 1450;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    typedef struct packed {
        logic [COLOUR_W-1:0] alpha;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic [OFFSET_W-1:0] offset;
    } pixel_write_t;

    class scaler_scoreboard;
        bit [RGB_W-1:0]          frame_mem [STORE_DEPTH];
        bit                      written [STORE_DEPTH];
        int unsigned             load_ptr;
        logic [SRC_WIDTH_W-1:0]  src_w;
        logic [SRC_HEIGHT_W-1:0] src_h;
        logic [TGT_SIZE_W-1:0]   tgt_w;
        logic [TGT_SIZE_W-1:0]   tgt_h;
        logic [STRIDE_W-1:0]     stride;
        pixel_write_t            pending_writes [$];
        int unsigned             fault_count;
        int unsigned             writes_checked;

        function new();
            load_ptr       = 0;
            src_w          = RST_SRC_WIDTH;
            src_h          = RST_SRC_HEIGHT;
            tgt_w          = RST_TGT_WIDTH;
            tgt_h          = RST_TGT_HEIGHT;
            stride         = RST_STRIDE;
            fault_count    = 0;
            writes_checked = 0;
        endfunction

        function int unsigned effective_size(int unsigned v, int unsigned maxv);
            if (v == 0)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        // truncating source lookup, clamped to the last column or row
        function int unsigned scale_coord(int unsigned c, int unsigned src,
                                          int unsigned tgt);
            longint unsigned q;
            q = (longint'(c) * src) / tgt;
            if (q >= src)
                q = src - 1;
            return int'(q);
        endfunction

        function int unsigned source_addr(logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
            int unsigned sw;
            int unsigned sh;
            sw = effective_size(src_w, DEF_MAX_SRC_WIDTH);
            sh = effective_size(src_h, DEF_MAX_SRC_HEIGHT);
            return scale_coord(ty, sh, effective_size(tgt_h, 2047)) * sw
                   + scale_coord(tx, sw, effective_size(tgt_w, 2047));
        endfunction

        // fetches only go to store entries that a load has filled
        function bit is_loaded(logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
            return written[source_addr(tx, ty)];
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SRC_WIDTH:  src_w  = val[SRC_WIDTH_W-1:0];
                CFG_SRC_HEIGHT: src_h  = val[SRC_HEIGHT_W-1:0];
                CFG_TGT_WIDTH:  tgt_w  = val[TGT_SIZE_W-1:0];
                CFG_TGT_HEIGHT: tgt_h  = val[TGT_SIZE_W-1:0];
                CFG_STRIDE:     stride = val[STRIDE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_beat(logic cmd, logic first, logic [COLOUR_W-1:0] r,
                                logic [COLOUR_W-1:0] g, logic [COLOUR_W-1:0] b,
                                logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
            int unsigned  addr;
            logic [31:0]  off;
            pixel_write_t pw;
            if (cmd == CMD_LOAD)
            begin
                if (first)
                    load_ptr = 0;
                // a full store drops the beat and keeps the pointer saturated
                if (load_ptr < STORE_DEPTH)
                begin
                    frame_mem[load_ptr] = {r, g, b};
                    written[load_ptr]   = 1'b1;
                    load_ptr++;
                end
                return;
            end
            addr = source_addr(tx, ty);
            off  = ty * stride + tx * 4;
            pw.offset = off[OFFSET_W-1:0];
            pw.blue   = frame_mem[addr][7:0];
            pw.green  = frame_mem[addr][15:8];
            pw.red    = frame_mem[addr][23:16];
            pw.alpha  = ALPHA_OPAQUE;
            pending_writes.push_back(pw);
        endfunction

        function void check_write(logic [OUT_TDATA_W-1:0] tdata);
            pixel_write_t got;
            pixel_write_t want;
            got = pixel_write_t'(tdata);
            if (pending_writes.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("tb_top: unexpected pixel write, offset %0d data %h",
                             got.offset, tdata);
                return;
            end
            want = pending_writes.pop_front();
            writes_checked++;
            if (got.offset !== want.offset || got.blue !== want.blue ||
                got.green !== want.green || got.red !== want.red ||
                got.alpha !== want.alpha)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display({"tb_top: mismatch on write %0d: exp off %0d bgra %h %h %h %h,",
                              " got off %0d bgra %h %h %h %h"},
                             writes_checked, want.offset, want.blue, want.green,
                             want.red, want.alpha, got.offset, got.blue, got.green,
                             got.red, got.alpha);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    scaler_scoreboard sb = new();

    logic        calm = 1'b0;
    int unsigned hold_request = 0;
    int unsigned stall_cycles = 0;
    int unsigned load_beats = 0;
    int unsigned fetch_beats = 0;
    int unsigned reg_writes = 0;

    nearest_neighbor_image_scaler_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sink side: random back-pressure, plus a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = calm || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_write(m_tdata);
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb_top: no beat moved for %0d cycles", STALL_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so back-to-back beats need no gap
    task automatic send_beat(input logic cmd, input logic first,
                             input logic [COLOUR_W-1:0] r, input logic [COLOUR_W-1:0] g,
                             input logic [COLOUR_W-1:0] b, input logic [COORD_W-1:0] tx,
                             input logic [COORD_W-1:0] ty);
        if (!calm && $urandom_range(99) < 15)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        s_tdata  = {2'b00, ty, tx, b, g, r};
        s_tuser  = {first, cmd};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(cmd, first, r, g, b, tx, ty);
        if (cmd == CMD_LOAD)
            load_beats++;
        else
            fetch_beats++;
        @(negedge clk);
    endtask

    task automatic send_load(input logic first, input logic [COLOUR_W-1:0] r,
                             input logic [COLOUR_W-1:0] g, input logic [COLOUR_W-1:0] b);
        send_beat(CMD_LOAD, first, r, g, b, COORD_W'($urandom_range(2047)),
                  COORD_W'($urandom_range(2047)));
    endtask

    task automatic send_fetch(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
        send_beat(CMD_FETCH, 1'($urandom_range(1)), COLOUR_W'($urandom_range(255)),
                  COLOUR_W'($urandom_range(255)), COLOUR_W'($urandom_range(255)), tx, ty);
    endtask

    task automatic send_random_load(input logic first);
        send_load(first, COLOUR_W'($urandom_range(255)), COLOUR_W'($urandom_range(255)),
                  COLOUR_W'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending_writes.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // loads leave no trace at the output, so give the block time to finish
    task automatic quiesce();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.write_register(idx, val);
        reg_writes++;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_sizes(input int unsigned sw, input int unsigned sh,
                               input int unsigned tw, input int unsigned th,
                               input int unsigned stride_bytes);
        quiesce();
        write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(sw));
        write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(sh));
        write_reg(CFG_TGT_WIDTH, CFG_DATA_W'(tw));
        write_reg(CFG_TGT_HEIGHT, CFG_DATA_W'(th));
        write_reg(CFG_STRIDE, CFG_DATA_W'(stride_bytes));
    endtask

    initial
    begin
        int unsigned random_beats;
        int unsigned sw;
        int unsigned sh;
        int unsigned tw;
        int unsigned th;
        int unsigned stride_bytes;
        int unsigned sw_e;
        int unsigned sh_e;
        int unsigned tw_e;
        int unsigned th_e;
        int unsigned run_len;
        logic        held;
        logic        paused;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;

        random_beats = 0;
        held         = 1'b0;
        paused       = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset settings, a restart mid-frame, then the odd sizes
        send_load(1'b1, 8'hFF, 8'h00, 8'hFF);
        send_load(1'b0, 8'h00, 8'hFF, 8'h00);
        send_load(1'b0, 8'h12, 8'h34, 8'h56);
        send_load(1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_load(1'b0, 8'h00, 8'h00, 8'h00);
        send_fetch(11'd0, 11'd0);
        send_fetch(11'd1, 11'd0);
        send_fetch(11'd2, 11'd0);
        // zero sizes act as one; largest stride makes the offset wrap
        apply_sizes(0, 0, 0, 0, 16383);
        send_fetch(11'd1919, 11'd1079);
        send_fetch(11'd2047, 11'd2047);
        // write to an index past the register list must change nothing
        quiesce();
        write_reg(CFG_SPARE_INDEX, '1);
        send_fetch(11'd1919, 11'd1079);
        // oversized source acts as the maximum
        apply_sizes(1023, 511, 1920, 1080, 4);
        send_fetch(11'd5, 11'd0);
        send_fetch(11'd8, 11'd2);
        // mapped column and row past the source get clamped
        apply_sizes(3, 1, 2, 1, 8192);
        send_fetch(11'd5, 11'd0);
        send_fetch(11'd1, 11'd0);
        send_fetch(11'd0, 11'd3);

        // a small full frame, then its corners, centre and a point past the end
        apply_sizes(16, 12, 40, 30, 160);
        for (int i = 0; i < 16 * 12; i++)
            send_random_load(i == 0);
        send_fetch(11'd39, 11'd29);
        send_fetch(11'd0, 11'd0);
        send_fetch(11'd20, 11'd15);
        send_fetch(11'd45, 11'd35);

        // random phases: fresh settings, at times a small frame, then fetches mixed with loads
        while (random_beats < RANDOM_BEATS)
        begin
            case ($urandom_range(9))
                0: sw = 0;
                1: sw = 1;
                2: sw = 640;
                3: sw = 1023;
                4: sw = $urandom_range(1023);
                default: sw = $urandom_range(16, 1);
            endcase
            case ($urandom_range(9))
                0: sh = 0;
                1: sh = 1;
                2: sh = 480;
                3: sh = 511;
                4: sh = $urandom_range(511);
                default: sh = $urandom_range(12, 1);
            endcase
            case ($urandom_range(9))
                0: tw = 0;
                1: tw = 1;
                2: tw = 1920;
                3: tw = 2047;
                4, 5: tw = $urandom_range(2047);
                default: tw = $urandom_range(64, 1);
            endcase
            case ($urandom_range(9))
                0: th = 0;
                1: th = 1;
                2: th = 1080;
                3: th = 2047;
                4, 5: th = $urandom_range(2047);
                default: th = $urandom_range(48, 1);
            endcase
            case ($urandom_range(9))
                0: stride_bytes = 0;
                1: stride_bytes = 4;
                2: stride_bytes = 8192;
                3: stride_bytes = 16383;
                default: stride_bytes = $urandom_range(16383);
            endcase
            apply_sizes(sw, sh, tw, th, stride_bytes);
            sw_e = sb.effective_size(sb.src_w, DEF_MAX_SRC_WIDTH);
            sh_e = sb.effective_size(sb.src_h, DEF_MAX_SRC_HEIGHT);
            tw_e = sb.effective_size(sb.tgt_w, 2047);
            th_e = sb.effective_size(sb.tgt_h, 2047);

            if (sw_e * sh_e <= 256 && $urandom_range(3) != 0)
            begin
                for (int i = 0; i < sw_e * sh_e; i++)
                begin
                    calm = (random_beats >= 600 && random_beats < 900);
                    send_random_load(i == 0);
                    random_beats++;
                end
            end

            run_len = $urandom_range(90, 30);
            for (int k = 0; k < run_len; k++)
            begin
                calm = (random_beats >= 600 && random_beats < 900);
                if (!held && random_beats >= 400)
                begin
                    hold_request = 400;
                    held         = 1'b1;
                end
                if (!paused && random_beats >= 1000)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
                if ($urandom_range(99) < 15)
                    send_random_load($urandom_range(3) == 0);
                else
                begin
                    tx = ($urandom_range(9) < 7) ? COORD_W'($urandom_range(tw_e - 1))
                                                 : COORD_W'($urandom_range(2047));
                    ty = ($urandom_range(9) < 7) ? COORD_W'($urandom_range(th_e - 1))
                                                 : COORD_W'($urandom_range(2047));
                    // fall back to the top row, where each frame's first loads land
                    for (int t = 0; t < 8 && !sb.is_loaded(tx, ty); t++)
                    begin
                        tx = COORD_W'($urandom_range(tw_e - 1));
                        ty = '0;
                    end
                    if (!sb.is_loaded(tx, ty))
                    begin
                        tx = '0;
                        ty = '0;
                    end
                    send_fetch(tx, ty);
                end
                random_beats++;
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb_top: %0d loads, %0d fetches, with a long sink hold-off and a drain,",
                 load_beats, fetch_beats);
        $display("tb_top: %0d pixel writes checked over %0d register writes",
                 sb.writes_checked, reg_writes);
        if (sb.fault_count == 0 && sb.pending_writes.size() == 0)
            $display("tb_top: done, clean");
        else
        begin
            $display("tb_top: %0d mismatches, %0d writes never seen",
                     sb.fault_count, sb.pending_writes.size());
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
